// ===== src/crc32b_pkg.sv =====
// Package for the configurable byte-serial CRC-32 engine.
// Holds shared widths, reset values, register indexes and the config struct.
// No dependencies.
package crc32b_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 2;

  localparam logic [CRC_W-1:0] POLY_RST = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] INIT_RST = 32'hFFFF_FFFF;

  typedef enum logic [IDX_W-1:0] {
    CFG_POLY    = 2'd0,
    CFG_INIT    = 2'd1,
    CFG_REFLECT = 2'd2,
    CFG_INVERT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] init_value;
    logic             reflect_mode;
    logic             invert_output;
  } cfg_t;

endpackage

// ===== src/crc32b_cfg.sv =====
// Configuration register bank for the CRC-32 engine.
// Depends on crc32b_pkg.
module crc32b_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [crc32b_pkg::IDX_W-1:0]       cfg_index,
  input  logic [crc32b_pkg::CRC_W-1:0]       cfg_wdata,
  output crc32b_pkg::cfg_t                   cfg
);

  crc32b_pkg::cfg_t cfg_r;
  crc32b_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (crc32b_pkg::cfg_idx_t'(cfg_index))
        crc32b_pkg::CFG_POLY:    cfg_nxt.polynomial    = cfg_wdata;
        crc32b_pkg::CFG_INIT:    cfg_nxt.init_value    = cfg_wdata;
        crc32b_pkg::CFG_REFLECT: cfg_nxt.reflect_mode  = cfg_wdata[0];
        crc32b_pkg::CFG_INVERT:  cfg_nxt.invert_output = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polynomial    <= crc32b_pkg::POLY_RST;
      cfg_r.init_value    <= crc32b_pkg::INIT_RST;
      cfg_r.reflect_mode  <= 1'b1;
      cfg_r.invert_output <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/crc32b_fold.sv =====
// Combinational fold of one byte into the CRC register, eight bit steps.
// Depends on crc32b_pkg.
module crc32b_fold (
  input  logic [crc32b_pkg::CRC_W-1:0]  crc_in,
  input  logic [crc32b_pkg::BYTE_W-1:0] data_byte,
  input  logic [crc32b_pkg::CRC_W-1:0]  polynomial,
  input  logic                          reflect_mode,
  output logic [crc32b_pkg::CRC_W-1:0]  crc_out
);

  localparam int unsigned W = crc32b_pkg::CRC_W;
  localparam int unsigned B = crc32b_pkg::BYTE_W;

  logic [W-1:0] poly_rev;
  logic [W-1:0] acc;

  always_comb begin
    for (int k = 0; k < W; k++) begin
      poly_rev[k] = polynomial[W-1-k];
    end
  end

  always_comb begin
    if (reflect_mode) begin
      acc = crc_in ^ {{(W-B){1'b0}}, data_byte};
      for (int k = 0; k < B; k++) begin
        acc = acc[0] ? ({1'b0, acc[W-1:1]} ^ poly_rev) : {1'b0, acc[W-1:1]};
      end
    end else begin
      acc = crc_in ^ {data_byte, {(W-B){1'b0}}};
      for (int k = 0; k < B; k++) begin
        acc = acc[W-1] ? ({acc[W-2:0], 1'b0} ^ polynomial) : {acc[W-2:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

// ===== src/configurable_crc32_byte.sv =====
// A byte is captured in the input register, then folded into the CRC register;
// a last byte's result is registered in out_crc_r and presented on out_*.
// Throughput: one byte per clock unless a last byte stalls on a held result;
// the eight-step fold sits between the input register and the CRC/result regs.
// Reset (rst_n low, synchronous): config registers return to CRC-32 defaults,
// CRC register loads 0xFFFFFFFF, both pipeline registers empty.
module configurable_crc32_byte (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [crc32b_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [crc32b_pkg::CRC_W-1:0]       out_crc_value,
  input  logic                               cfg_wr_en,
  input  logic [crc32b_pkg::IDX_W-1:0]       cfg_index,
  input  logic [crc32b_pkg::CRC_W-1:0]       cfg_wdata
);

  crc32b_pkg::cfg_t cfg;

  logic                              in_valid_r, in_valid_nxt;
  logic [crc32b_pkg::BYTE_W-1:0]     in_data_r;
  logic                              in_last_r;
  logic [crc32b_pkg::CRC_W-1:0]      crc_r, crc_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [crc32b_pkg::CRC_W-1:0]      out_crc_r;
  logic [crc32b_pkg::CRC_W-1:0]      fold_crc;
  logic                              out_free;
  logic                              adv;

  crc32b_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  crc32b_fold u_fold (
    .crc_in       (crc_r),
    .data_byte    (in_data_r),
    .polynomial   (cfg.polynomial),
    .reflect_mode (cfg.reflect_mode),
    .crc_out      (fold_crc)
  );

  // non-last bytes never wait on the result side
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = in_valid_r && (!in_last_r || out_free);
  assign in_stall = in_valid_r && !adv;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
    end

    crc_nxt = crc_r;
    if (adv) begin
      crc_nxt = in_last_r ? cfg.init_value : fold_crc;
    end

    out_valid_nxt = out_valid_r;
    if (adv && in_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= crc32b_pkg::INIT_RST;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      crc_r       <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
    if (adv && in_last_r) begin
      out_crc_r <= cfg.invert_output ? ~fold_crc : fold_crc;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

`ifndef SYNTH
  a_rise_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r && in_last_r))
    else $error("result appeared without a last byte");

  a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_last_r) |=> (crc_r == $past(cfg.init_value)))
    else $error("CRC register not reloaded after last byte");

  a_mid_msg_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !in_last_r) |-> !in_stall)
    else $error("stall raised on a non-last byte");
`endif

endmodule
